[src/rmcq_pkg.sv]
package rmcq_pkg;

  // default number of queue cells
  localparam int QUEUE_DEPTH_DEF = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_SET_MODE = 2'd0,
    OP_STEP     = 2'd1,
    OP_DEQUEUE  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // last reject reason codes
  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_INVALID = 2'd1,
    REASON_FULL    = 2'd2,
    REASON_STEP    = 2'd3
  } reason_t;

  // run mode codes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_STEP    = 2'd1;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // command kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // one queued command
  typedef struct packed {
    logic        kind;
    logic [1:0]  mode;
    logic [31:0] time_us;
    logic [31:0] tag;
  } entry_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

[src/run_mode_command_queue.sv]
// channel  | handshake             | fields
// ---------+-----------------------+---------------------------------------------------
// item in  | start && !busy        | operation, mode_request, time_us, request_tag
// result   | done (one-cycle pulse)| ok, reject_reason, out_kind, out_mode, out_time_us,
//          |                       | out_tag, fill_level, fill_peak, requested_total,
//          |                       | accepted_total, rejected_total
//
// one item per cycle: busy stays low, the result is registered and shows in the cycle after the accepting edge
// the queue is a row of QUEUE_DEPTH cells; the head cell is read directly, a pop shifts
// every cell toward the head in the same cycle, a push loads the cell at the fill level
// rst is synchronous; it clears pointers, counters, mode and reason, not the cell contents
// the receiver cannot stall: each result is shown for exactly one cycle
module run_mode_command_queue #(
  parameter int QUEUE_DEPTH = rmcq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  operation,
  input  logic [1:0]  mode_request,
  input  logic [31:0] time_us,
  input  logic [31:0] request_tag,
  output logic        busy,
  output logic        done,
  output logic        ok,
  output logic [1:0]  reject_reason,
  output logic        out_kind,
  output logic [1:0]  out_mode,
  output logic [31:0] out_time_us,
  output logic [31:0] out_tag,
  output logic [4:0]  fill_level,
  output logic [4:0]  fill_peak,
  output logic [31:0] requested_total,
  output logic [31:0] accepted_total,
  output logic [31:0] rejected_total
);
  import rmcq_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  // state registers
  logic [LW-1:0] level, level_next;
  logic [LW-1:0] peak_level, peak_level_next;
  logic [1:0]    wanted_mode, wanted_mode_next;
  reason_t       last_reason, last_reason_next;
  logic [31:0]   req_count, req_count_next;
  logic [31:0]   acc_count, acc_count_next;
  logic [31:0]   rej_count, rej_count_next;

  // result registers
  logic          ok_next;
  entry_t        out_entry, out_entry_next;

  // queue control
  logic          accept;
  logic          is_full;
  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        cell_data [QUEUE_DEPTH];

  // the queue never holds off an item
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_full = (level == LW'(QUEUE_DEPTH));

  always_comb begin
    level_next       = level;
    wanted_mode_next = wanted_mode;
    last_reason_next = last_reason;
    req_count_next   = req_count;
    acc_count_next   = acc_count;
    rej_count_next   = rej_count;
    push             = 1'b0;
    pop              = 1'b0;
    ok_next          = 1'b0;
    out_entry_next   = '0;
    push_entry       = '{kind: KIND_SET, mode: mode_request, time_us: time_us,
                         tag: request_tag};
    if (accept) begin
      case (op_t'(operation))
        OP_SET_MODE: begin
          req_count_next = req_count + 32'd1;
          // mode check comes before the room check
          if (mode_request == MODE_INVALID) begin
            rej_count_next   = rej_count + 32'd1;
            last_reason_next = REASON_INVALID;
          end else if (is_full) begin
            rej_count_next   = rej_count + 32'd1;
            last_reason_next = REASON_FULL;
          end else begin
            push             = 1'b1;
            wanted_mode_next = mode_request;
            acc_count_next   = acc_count + 32'd1;
            last_reason_next = REASON_NONE;
            ok_next          = 1'b1;
          end
        end
        OP_STEP: begin
          req_count_next = req_count + 32'd1;
          push_entry.kind = KIND_STEP;
          push_entry.mode = MODE_NORMAL;
          // step needs step mode, whatever the fill level
          if (wanted_mode != MODE_STEP) begin
            rej_count_next   = rej_count + 32'd1;
            last_reason_next = REASON_STEP;
          end else if (is_full) begin
            rej_count_next   = rej_count + 32'd1;
            last_reason_next = REASON_FULL;
          end else begin
            push             = 1'b1;
            acc_count_next   = acc_count + 32'd1;
            last_reason_next = REASON_NONE;
            ok_next          = 1'b1;
          end
        end
        OP_DEQUEUE: begin
          // empty queue: no change, ok stays low
          if (level != '0) begin
            pop            = 1'b1;
            ok_next        = 1'b1;
            out_entry_next = cell_data[0];
          end
        end
        default: begin
          // unused code: item ignored
        end
      endcase
    end
    if (push) begin
      level_next = level + LW'(1);
    end else if (pop) begin
      level_next = level - LW'(1);
    end
    peak_level_next = (level_next > peak_level) ? level_next : peak_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= '0;
      peak_level  <= '0;
      wanted_mode <= MODE_NORMAL;
      last_reason <= REASON_NONE;
      req_count   <= '0;
      acc_count   <= '0;
      rej_count   <= '0;
      done        <= 1'b0;
      ok          <= 1'b0;
    end else begin
      level       <= level_next;
      peak_level  <= peak_level_next;
      wanted_mode <= wanted_mode_next;
      last_reason <= last_reason_next;
      req_count   <= req_count_next;
      acc_count   <= acc_count_next;
      rej_count   <= rej_count_next;
      done        <= accept;
      ok          <= ok_next;
    end
  end

  // dequeued command payload
  always_ff @(posedge clk) begin
    out_entry <= out_entry_next;
  end

  // row of cells, cell 0 is the oldest command
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     next_data;

    assign ctrl.load  = push && (level == LW'(i));
    assign ctrl.shift = pop;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_data = cell_data[i];
    end else begin : g_body
      assign next_data = cell_data[i+1];
    end

    rmcq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (push_entry),
      .next_data (next_data),
      .data      (cell_data[i])
    );
  end

  // state registers already hold the post-item values during the result cycle
  assign reject_reason   = last_reason;
  assign out_kind        = out_entry.kind;
  assign out_mode        = out_entry.mode;
  assign out_time_us     = out_entry.time_us;
  assign out_tag         = out_entry.tag;
  assign fill_level      = 5'(level);
  assign fill_peak       = 5'(peak_level);
  assign requested_total = req_count;
  assign accepted_total  = acc_count;
  assign rejected_total  = rej_count;

`ifndef SYNTHESIS
  // fill level stays within the row of cells
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // peak never falls below the current level
  a_peak_ge_level: assert property (@(posedge clk) disable iff (rst)
    peak_level >= level)
    else $error("peak below level");

  // every request is either accepted or rejected
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    req_count == acc_count + rej_count)
    else $error("request counters out of balance");

  // one result for each accepted item, in the following cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("missing result strobe");

  // a pop from an empty queue reports failure
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_DEQUEUE && level == '0) |=> (!ok && fill_level == 5'd0))
    else $error("pop from empty queue reported ok");

  // a cell never loads and shifts at once
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(push && pop))
    else $error("push and pop in one cycle");
`endif

endmodule

[src/rmcq_cell.sv]
module rmcq_cell (
  input  logic                clk,
  input  rmcq_pkg::cell_ctrl_t ctrl,
  input  rmcq_pkg::entry_t    load_data,
  input  rmcq_pkg::entry_t    next_data,
  output rmcq_pkg::entry_t    data
);
  import rmcq_pkg::*;

  // load a new command, or take the neighbor's on a pop
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= next_data;
    end
  end

endmodule
